// File: rtl/core/plateau_peak_detector_defines.svh
// ----------------------------------------------------------------------------
// Plateau peak detector assertion macros
// Shared concurrent assertion forms, clocked on clock; all but the last are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PLATEAU_PEAK_DETECTOR_DEFINES_SVH
`define PLATEAU_PEAK_DETECTOR_DEFINES_SVH

// same-cycle implication, off while reset is high
`define PKD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define PKD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that is also checked across reset
`define PKD_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pkd_pkg.sv
// ----------------------------------------------------------------------------
// Plateau peak detector package
// Field widths, register indexes and shared types.
// ----------------------------------------------------------------------------
package pkd_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int INDEX_WIDTH  = 16;
   localparam int CSR_ADDR_WIDTH = 2;

   // longest sequence; samples past the last index are ignored
   localparam int MAX_LENGTH = 65536;

   // configuration register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_THRESHOLD_LOW  = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_THRESHOLD_HIGH = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_LIST_LIMIT     = 2'd2;

   // configuration as seen by the tracking logic
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] threshold_low;
      logic signed [SAMPLE_WIDTH-1:0] threshold_high;
      logic        [INDEX_WIDTH-1:0]  list_limit;
   } pkd_cfg_type;

   // one reported peak
   typedef struct packed {
      logic        [INDEX_WIDTH-1:0]  peak_ordinal;
      logic signed [SAMPLE_WIDTH-1:0] peak_value;
      logic        [INDEX_WIDTH-1:0]  peak_position;
   } pkd_result_type;

endpackage

// File: rtl/core/pkd_csr.sv
// ----------------------------------------------------------------------------
// Plateau peak detector configuration registers
// Holds the thresholds and the per-sequence peak limit.
// ----------------------------------------------------------------------------
module pkd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pkd_pkg::CSR_ADDR_WIDTH-1:0]   csr_index,
   input  logic [pkd_pkg::SAMPLE_WIDTH-1:0]     csr_wdata,
   output pkd_pkg::pkd_cfg_type                 cfg
);

   pkd_pkg::pkd_cfg_type cfg_ff;
   pkd_pkg::pkd_cfg_type cfg_in;

   // writes are always accepted
   assign csr_ready = 1'b1;

   // register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pkd_pkg::REG_THRESHOLD_LOW:  cfg_in.threshold_low  = csr_wdata;
            pkd_pkg::REG_THRESHOLD_HIGH: cfg_in.threshold_high = csr_wdata;
            pkd_pkg::REG_LIST_LIMIT:     cfg_in.list_limit     = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_low  <= 16'sh8000;
         cfg_ff.threshold_high <= 16'sh7fff;
         cfg_ff.list_limit     <= 16'hffff;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/pkd_track.sv
// ----------------------------------------------------------------------------
// Plateau peak detector tracking logic
// Per-sequence slope/plateau state and the combinational peak decision.
// ----------------------------------------------------------------------------
module pkd_track (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic signed [pkd_pkg::SAMPLE_WIDTH-1:0] sample,
   input  logic                                 first_sample,
   input  pkd_pkg::pkd_cfg_type                 cfg,
   output logic                                 peak_valid,
   output pkd_pkg::pkd_result_type              peak
);

   localparam int IW = pkd_pkg::INDEX_WIDTH;
   localparam int SW = pkd_pkg::SAMPLE_WIDTH;

   logic signed [SW-1:0] prev_ff, prev_in, prev_eff;
   logic                 rising_ff, rising_in, rising_eff;
   logic [IW-1:0]        plateau_ff, plateau_in, plateau_eff;
   logic [IW-1:0]        index_ff, index_in, index_eff;
   logic [IW-1:0]        peaks_ff, peaks_in, peaks_eff;
   logic                 stopped_ff, stopped_in, stopped_eff;

   logic signed [SW-1:0] thr_low;
   logic signed [SW-1:0] thr_high;
   logic                 flat;
   logic                 fall;
   logic                 candidate;
   logic                 in_range;
   logic                 hit;
   logic                 list_full;
   logic                 last_index;
   logic [IW-1:0]        half_run;
   logic [IW-1:0]        position;

   assign thr_low  = cfg.threshold_low;
   assign thr_high = cfg.threshold_high;

   // a first sample sees a cleared sequence
   always_comb begin
      prev_eff    = first_sample ? '0   : prev_ff;
      rising_eff  = first_sample ? 1'b0 : rising_ff;
      plateau_eff = first_sample ? '0   : plateau_ff;
      index_eff   = first_sample ? '0   : index_ff;
      peaks_eff   = first_sample ? '0   : peaks_ff;
      stopped_eff = first_sample ? 1'b0 : stopped_ff;
   end

   // slope, plateau middle and qualification
   always_comb begin
      flat       = (sample == prev_eff);
      fall       = (sample < prev_eff);
      candidate  = fall && ((plateau_eff != '0) || rising_eff);
      half_run   = IW'(({1'b0, plateau_eff} + {{IW{1'b0}}, 1'b1}) >> 1);
      position   = (plateau_eff != '0) ? (index_eff - half_run - IW'(1))
                                       : (index_eff - IW'(1));
      in_range   = (prev_eff >= thr_low) && (prev_eff <= thr_high);
      hit        = candidate && in_range && !stopped_eff;
      list_full  = (peaks_eff >= cfg.list_limit);
      last_index = (({1'b0, index_eff} + (IW+1)'(1)) >= (IW+1)'(pkd_pkg::MAX_LENGTH));
   end

   // next state
   always_comb begin
      prev_in    = prev_eff;
      rising_in  = rising_eff;
      plateau_in = plateau_eff;
      index_in   = index_eff;
      peaks_in   = peaks_eff;
      stopped_in = stopped_eff;
      if (!stopped_eff) begin
         if (flat) begin
            plateau_in = rising_eff ? (plateau_eff + IW'(1)) : '0;
         end else begin
            plateau_in = '0;
            rising_in  = !fall;
         end
         if (hit && list_full) begin
            // list is full: drop the peak and ignore the rest of the sequence
            stopped_in = 1'b1;
         end else begin
            if (hit) begin
               peaks_in = peaks_eff + IW'(1);
            end
            prev_in = sample;
            if (last_index) begin
               stopped_in = 1'b1;
            end else begin
               index_in = index_eff + IW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         rising_ff  <= 1'b0;
         plateau_ff <= '0;
         index_ff   <= '0;
         peaks_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (step) begin
         prev_ff    <= prev_in;
         rising_ff  <= rising_in;
         plateau_ff <= plateau_in;
         index_ff   <= index_in;
         peaks_ff   <= peaks_in;
         stopped_ff <= stopped_in;
      end
   end

   // result for this sample
   assign peak_valid         = hit && !list_full;
   assign peak.peak_position = position;
   assign peak.peak_value    = prev_eff;
   assign peak.peak_ordinal  = peaks_eff + IW'(1);

endmodule

// File: rtl/core/plateau_peak_detector.sv
// ----------------------------------------------------------------------------
// Plateau peak detector
// Streams 16-bit signed samples and reports local maxima and plateau middles.
// ----------------------------------------------------------------------------
// One sample is taken per clock when the result side keeps up. A sample goes
// into an input register, is judged combinationally against the tracking
// state and any peak lands in the output register, which drives rsp_tvalid
// and rsp_tdata. Throughput is set by the single tracking update per cycle;
// a stalled result register holds the input register too.
// Configuration writes are always accepted and should be made while no
// sample is in flight.
// ----------------------------------------------------------------------------
module plateau_peak_detector (
   input  logic        clock,
   input  logic        reset,
   // sample input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tuser,   // [0] first_sample
   // peak results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] peak_position, [31:16] peak_value,
                                    // [47:32] peak_ordinal
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   pkd_pkg::pkd_cfg_type    cfg;
   pkd_pkg::pkd_result_type peak;
   pkd_pkg::pkd_result_type out_ff;
   logic                    peak_valid;

   logic               in_valid_ff, in_valid_in;
   logic signed [15:0] in_sample_ff;
   logic               in_first_ff;
   logic               out_valid_ff, out_valid_in;
   logic               advance;

   pkd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pkd_track u_track (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .sample       (in_sample_ff),
      .first_sample (in_first_ff),
      .cfg          (cfg),
      .peak_valid   (peak_valid),
      .peak         (peak)
   );

   // input stage moves on when the output register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = peak_valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_sample_ff <= req_tdata;
         in_first_ff  <= req_tuser;
      end
      if (advance && peak_valid) begin
         out_ff <= peak;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

// File: rtl/core/pkd_checker.sv
// ----------------------------------------------------------------------------
// Plateau peak detector port checker
// Watches the top-level ports for ordering and result sanity.
// ----------------------------------------------------------------------------
`include "plateau_peak_detector_defines.svh"

module pkd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // a stalled result transaction keeps its data
   `PKD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // no result is pending right after reset
   `PKD_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_tvalid, "result valid after reset")

   // ordinals count from one
   `PKD_ASSERT_NOW(a_ordinal_nonzero, rsp_tvalid, rsp_tdata[47:32] != 16'd0, "zero peak ordinal")

   // a new result follows an accepted sample through the input and output registers
   `PKD_ASSERT_NOW(a_result_latency, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2), "result without sample")

endmodule

bind plateau_peak_detector pkd_checker u_pkd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
